// ----- rtl/core/ssfp_pkg.sv -----
// Shared types and constants for the substring search block.
package ssfp_pkg;

	// Capacity of each byte store
	localparam int unsigned MAX_LEN = 255;
	// Store address width
	localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	// 1-based scan index width: holds up to 256
	localparam int unsigned IDX_W = 9;

	typedef enum logic [1:0] {
		MODE_TEXT   = 2'd0,
		MODE_PAT    = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_SEARCH = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] char_value;
		logic [7:0] start_pos;
	} item_t;

	typedef struct packed {
		logic [7:0] match_position;
		logic       dropped;
	} result_t;

	// One port pair of a store: write side and read address
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

// ----- rtl/core/ssfp_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module ssfp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 255
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on enable, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/ssfp_ctrl.sv -----
// Command decode, store lengths and the byte-compare scan sequencer.
module ssfp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ssfp_pkg::item_t   item,
	output logic              busy,
	output logic              done,
	output ssfp_pkg::result_t result,
	output ssfp_pkg::ram_req_t text_req,
	output ssfp_pkg::ram_req_t pat_req,
	input  logic [7:0]        text_rdata,
	input  logic [7:0]        pat_rdata
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t                          state_q, state_d;
	logic [7:0]                      tlen_q, tlen_d;
	logic [7:0]                      plen_q, plen_d;
	logic [ssfp_pkg::IDX_W-1:0]      i_q, i_d;
	logic [ssfp_pkg::IDX_W-1:0]      j_q, j_d;
	logic                            done_q, done_d;
	ssfp_pkg::result_t               result_q, result_d;

	logic                            accept;
	logic                            start_ok;
	logic                            eq;
	logic [ssfp_pkg::IDX_W-1:0]      ni, nj;
	logic [ssfp_pkg::IDX_W-1:0]      start_ext;
	logic [ssfp_pkg::IDX_W-1:0]      tlen_ext, plen_ext;

	assign busy      = (state_q == ST_SCAN);
	assign accept    = start && !busy;
	assign start_ext = {1'b0, item.start_pos};
	assign tlen_ext  = {1'b0, tlen_q};
	assign plen_ext  = {1'b0, plen_q};
	assign start_ok  = (item.start_pos != 8'd0) && (item.start_pos <= tlen_q);

	// Next alignment step from the bytes read last cycle
	assign eq = (text_rdata == pat_rdata);
	assign ni = eq ? (i_q + ssfp_pkg::IDX_W'(1)) : (i_q - j_q + ssfp_pkg::IDX_W'(2));
	assign nj = eq ? (j_q + ssfp_pkg::IDX_W'(1)) : ssfp_pkg::IDX_W'(1);

	// Decode commands and advance the scan
	always_comb begin
		state_d  = state_q;
		tlen_d   = tlen_q;
		plen_d   = plen_q;
		i_d      = i_q;
		j_d      = j_q;
		done_d   = 1'b0;
		result_d = result_q;

		text_req       = '0;
		pat_req        = '0;
		text_req.wdata = item.char_value;
		pat_req.wdata  = item.char_value;
		text_req.waddr = tlen_q[ssfp_pkg::ADDR_W-1:0];
		pat_req.waddr  = plen_q[ssfp_pkg::ADDR_W-1:0];

		unique case (state_q)
			ST_IDLE: begin
				// Fetch the first pair in case this is a search
				text_req.raddr = ssfp_pkg::ADDR_W'(start_ext - ssfp_pkg::IDX_W'(1));
				pat_req.raddr  = '0;
				if (accept) begin
					done_d   = 1'b1;
					result_d = '0;
					unique case (item.mode)
						ssfp_pkg::MODE_TEXT: begin
							if (tlen_q == 8'(ssfp_pkg::MAX_LEN)) begin
								result_d.dropped = 1'b1;
							end else begin
								text_req.we = 1'b1;
								tlen_d      = tlen_q + 8'd1;
							end
						end
						ssfp_pkg::MODE_PAT: begin
							if (plen_q == 8'(ssfp_pkg::MAX_LEN)) begin
								result_d.dropped = 1'b1;
							end else begin
								pat_req.we = 1'b1;
								plen_d     = plen_q + 8'd1;
							end
						end
						ssfp_pkg::MODE_CLEAR: begin
							tlen_d = 8'd0;
							plen_d = 8'd0;
						end
						ssfp_pkg::MODE_SEARCH: begin
							priority if (!start_ok) begin
								result_d.match_position = 8'd0;
							end else if (plen_q == 8'd0) begin
								result_d.match_position = item.start_pos;
							end else begin
								// Hold the result until the scan ends
								done_d  = 1'b0;
								i_d     = start_ext;
								j_d     = ssfp_pkg::IDX_W'(1);
								state_d = ST_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				text_req.raddr = ssfp_pkg::ADDR_W'(ni - ssfp_pkg::IDX_W'(1));
				pat_req.raddr  = ssfp_pkg::ADDR_W'(nj - ssfp_pkg::IDX_W'(1));
				i_d = ni;
				j_d = nj;
				priority if (nj > plen_ext) begin
					done_d                  = 1'b1;
					result_d.match_position = 8'(ni - plen_ext);
					result_d.dropped        = 1'b0;
					state_d                 = ST_IDLE;
				end else if (ni > tlen_ext) begin
					done_d                  = 1'b1;
					result_d.match_position = 8'd0;
					result_d.dropped        = 1'b0;
					state_d                 = ST_IDLE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tlen_q  <= 8'd0;
			plen_q  <= 8'd0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			tlen_q  <= tlen_d;
			plen_q  <= plen_d;
			done_q  <= done_d;
		end
	end

	// Scan indexes and result payload
	always_ff @(posedge clk) begin
		i_q      <= i_d;
		j_q      <= j_d;
		result_q <= result_d;
	end

	assign done   = done_q;
	assign result = result_q;

	// Leaving the scan always delivers a result
	a_scan_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("scan ended without a result strobe");

	// Stores are never written during a scan
	a_no_write_scan: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (!text_req.we && !pat_req.we))
		else $error("store write during scan");

	// Scan indexes stay inside the live strings
	a_idx_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> ((j_q <= plen_ext) && (i_q <= tlen_ext) && (j_q != '0) && (i_q >= j_q)))
		else $error("scan index out of range");

	// A drop and a match never come together
	a_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.dropped) |-> (result.match_position == 8'd0))
		else $error("drop flagged with a match position");

	// Lengths never pass the store capacity
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(tlen_q <= 8'(ssfp_pkg::MAX_LEN)) && (plen_q <= 8'(ssfp_pkg::MAX_LEN)))
		else $error("store length above capacity");

endmodule

// ----- rtl/core/substring_search_from_position.sv -----
// Top level of the brute-force substring search block.
//
// Usage: drive item and raise start; the item transfers at a rising edge
// where start is high and busy is low. item.mode selects append text byte,
// append pattern byte, clear both stores, or search from item.start_pos.
// Every item produces exactly one result: done is high for one cycle with
// result.match_position (1-based, 0 for no match or non-search) and
// result.dropped (append ignored because the store was full).
// Appends, clears, and searches with an invalid start position or an
// empty pattern give their result in the cycle after the transfer and keep
// busy low, so one such item can transfer every cycle.
// A scanning search raises busy for S byte compares, one compare per cycle,
// paced by the read ports of the text and pattern memories. S is at most
// about text length times pattern length. busy falls in the cycle the
// result shows, so the next item may transfer there.
// Reset clears both lengths, the scan state and done; store contents are
// left as is and are only read below the current lengths.
// The receiver cannot stall: results must be taken in their done cycle.
module substring_search_from_position (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ssfp_pkg::item_t   item,
	output logic              busy,
	output logic              done,
	output ssfp_pkg::result_t result
);

	ssfp_pkg::ram_req_t text_req;
	ssfp_pkg::ram_req_t pat_req;
	logic [7:0]         text_rdata;
	logic [7:0]         pat_rdata;

	// Command decode and scan sequencer
	ssfp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.busy       (busy),
		.done       (done),
		.result     (result),
		.text_req   (text_req),
		.pat_req    (pat_req),
		.text_rdata (text_rdata),
		.pat_rdata  (pat_rdata)
	);

	// Text byte store
	ssfp_ram #(
		.WIDTH (8),
		.DEPTH (ssfp_pkg::MAX_LEN)
	) u_text_ram (
		.clk   (clk),
		.we    (text_req.we),
		.waddr (text_req.waddr),
		.wdata (text_req.wdata),
		.raddr (text_req.raddr),
		.rdata (text_rdata)
	);

	// Pattern byte store
	ssfp_ram #(
		.WIDTH (8),
		.DEPTH (ssfp_pkg::MAX_LEN)
	) u_pat_ram (
		.clk   (clk),
		.we    (pat_req.we),
		.waddr (pat_req.waddr),
		.wdata (pat_req.wdata),
		.raddr (pat_req.raddr),
		.rdata (pat_rdata)
	);

endmodule

// ----- bench/tb_substring_search_from_position.sv -----
// Self-checking testbench for the brute-force substring search block.
module tb_substring_search_from_position;
	timeunit 1ns;
	timeprecision 1ps;

	import ssfp_pkg::*;

	// Cycles without any transfer before the run is declared hung; a full-store
	// search takes up to about MAX_LEN * MAX_LEN compares.
	localparam int unsigned WATCHDOG_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES   = 10;
	localparam int unsigned PHASE_ITEMS    = 180;
	localparam logic [7:0]  FILL_BYTE      = 8'h41;
	localparam logic [7:0]  TAIL_BYTE      = 8'h42;

	// Predicts each result from its own copy of both stores and checks results
	// in order against the predictions.
	class search_scoreboard;
		logic [7:0]  text_mem [MAX_LEN];
		logic [7:0]  pat_mem [MAX_LEN];
		int unsigned text_len = 0;
		int unsigned pat_len = 0;
		result_t     expected_results [$];
		int unsigned errors = 0;

		// First 1-based alignment at or after pos where the pattern occurs, else 0
		function int unsigned find_occurrence(int unsigned pos);
			int unsigned i;
			int unsigned j;
			if (pos < 1 || pos > text_len)
				return 0;
			i = pos;
			j = 1;
			while (i <= text_len && j <= pat_len) begin
				if (text_mem[i-1] == pat_mem[j-1]) begin
					i++;
					j++;
				end else begin
					// fall back to one past the current alignment
					i = i + 2 - j;
					j = 1;
				end
			end
			if (j > pat_len)
				return i - pat_len;
			return 0;
		endfunction

		// Update the stores for one input transfer and queue its result
		function void note_item(item_t it);
			result_t r;
			r = '0;
			case (it.mode)
				MODE_TEXT: begin
					if (text_len >= MAX_LEN) begin
						r.dropped = 1'b1;
					end else begin
						text_mem[text_len] = it.char_value;
						text_len++;
					end
				end
				MODE_PAT: begin
					if (pat_len >= MAX_LEN) begin
						r.dropped = 1'b1;
					end else begin
						pat_mem[pat_len] = it.char_value;
						pat_len++;
					end
				end
				MODE_CLEAR: begin
					text_len = 0;
					pat_len = 0;
				end
				default: begin
					r.match_position = 8'(find_occurrence(it.start_pos));
				end
			endcase
			expected_results.push_back(r);
		endfunction

		// Compare one result transfer with the oldest prediction
		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result match_position=%0d dropped=%0b",
					$time, got.match_position, got.dropped);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (got.match_position !== want.match_position) begin
				$display("%0t: match_position expected %0d, got %0d",
					$time, want.match_position, got.match_position);
				errors++;
			end
			if (got.dropped !== want.dropped) begin
				$display("%0t: dropped expected %0b, got %0b",
					$time, want.dropped, got.dropped);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	item_t   item = '0;
	logic    busy;
	logic    done;
	result_t result;

	search_scoreboard sb;
	int unsigned idle_pct = 0;
	int unsigned sent_items = 0;
	int unsigned quiet_cycles = 0;
	int unsigned idle_by_phase [4] = '{0, 86, 0, 32};

	substring_search_from_position u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	// Check the result before noting a transfer in the same edge: a result
	// always belongs to an earlier item
	always @(posedge clk) begin
		if (done)
			sb.check_result(result);
		if (start && !busy)
			sb.note_item(item);
	end

	// Abort when nothing transfers for too long
	always @(posedge clk) begin
		if (done || (start && !busy)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic item_t make_item(mode_t m, logic [7:0] ch, logic [7:0] pos);
		item_t it;
		it.mode = m;
		it.char_value = ch;
		it.start_pos = pos;
		return it;
	endfunction

	// Drive one item after random idle cycles and hold it until it transfers
	task automatic send_item(mode_t m, logic [7:0] ch, logic [7:0] pos);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			item <= make_item(mode_t'($urandom_range(3)), 8'($urandom()), 8'($urandom()));
			@(negedge clk);
		end
		start <= 1'b1;
		item <= make_item(m, ch, pos);
		do @(posedge clk); while (busy);
		sent_items++;
		@(negedge clk);
	endtask

	// Short hand-picked items: empty stores, extreme bytes, bad start positions
	task automatic run_directed();
		send_item(MODE_SEARCH, 8'h00, 8'd0);
		send_item(MODE_SEARCH, 8'hFF, 8'd1);
		send_item(MODE_TEXT, 8'h00, 8'hFF);
		send_item(MODE_TEXT, 8'hFF, 8'h00);
		send_item(MODE_TEXT, 8'h00, 8'h00);
		send_item(MODE_TEXT, 8'hFF, 8'hFF);
		// empty pattern returns the start position
		send_item(MODE_SEARCH, 8'h00, 8'd1);
		send_item(MODE_SEARCH, 8'h00, 8'd4);
		// start outside the text
		send_item(MODE_SEARCH, 8'h00, 8'd5);
		send_item(MODE_SEARCH, 8'hFF, 8'd255);
		send_item(MODE_SEARCH, 8'h00, 8'd0);
		send_item(MODE_PAT, 8'hFF, 8'h00);
		send_item(MODE_PAT, 8'h00, 8'hFF);
		send_item(MODE_SEARCH, 8'h00, 8'd1);
		send_item(MODE_SEARCH, 8'h00, 8'd3);
		// runs off the end of the text
		send_item(MODE_SEARCH, 8'h00, 8'd4);
		send_item(MODE_PAT, 8'h00, 8'h00);
		send_item(MODE_SEARCH, 8'h00, 8'd1);
		send_item(MODE_CLEAR, 8'hFF, 8'hFF);
		send_item(MODE_SEARCH, 8'h00, 8'd1);
	endtask

	// Fill both stores to capacity, push past it, and search the full stores
	task automatic run_full_stores();
		send_item(MODE_CLEAR, 8'($urandom()), 8'($urandom()));
		for (int k = 0; k < MAX_LEN; k++)
			send_item(MODE_TEXT, (k == MAX_LEN - 1) ? TAIL_BYTE : FILL_BYTE, 8'($urandom()));
		repeat (3) send_item(MODE_TEXT, 8'($urandom()), 8'($urandom()));
		send_item(MODE_SEARCH, 8'h00, 8'd255);
		send_item(MODE_PAT, TAIL_BYTE, 8'h00);
		send_item(MODE_SEARCH, 8'h00, 8'd255);
		send_item(MODE_SEARCH, 8'h00, 8'd1);
		send_item(MODE_CLEAR, 8'($urandom()), 8'($urandom()));
		for (int k = 0; k < MAX_LEN; k++)
			send_item(MODE_TEXT, (k == MAX_LEN - 1) ? TAIL_BYTE : FILL_BYTE, 8'($urandom()));
		for (int k = 0; k < MAX_LEN; k++)
			send_item(MODE_PAT, (k == MAX_LEN - 1) ? TAIL_BYTE : FILL_BYTE, 8'($urandom()));
		repeat (3) send_item(MODE_PAT, 8'($urandom()), 8'($urandom()));
		send_item(MODE_SEARCH, 8'h00, 8'd1);
		send_item(MODE_SEARCH, 8'h00, 8'd2);
		send_item(MODE_SEARCH, 8'h00, 8'd0);
		send_item(MODE_CLEAR, 8'($urandom()), 8'($urandom()));
	endtask

	// One random sequence: mostly clear, small-alphabet appends and searches;
	// sometimes plain noise
	task automatic run_random_sequence();
		logic [7:0]  alphabet [4];
		int unsigned n_sym;
		int unsigned t_add;
		int unsigned p_add;
		logic [7:0]  pos;
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 6))
				send_item(mode_t'($urandom_range(3)), 8'($urandom()), 8'($urandom()));
			return;
		end
		if ($urandom_range(4) != 0 || sb.text_len > 200 || sb.pat_len > 200)
			send_item(MODE_CLEAR, 8'($urandom()), 8'($urandom()));
		n_sym = $urandom_range(1, 4);
		foreach (alphabet[k])
			alphabet[k] = 8'($urandom());
		t_add = ($urandom_range(19) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
		p_add = ($urandom_range(9) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
		// interleave text and pattern appends at random
		while (t_add + p_add > 0) begin
			if ($urandom_range(t_add + p_add - 1) < t_add) begin
				send_item(MODE_TEXT, alphabet[$urandom_range(n_sym - 1)], 8'($urandom()));
				t_add--;
			end else begin
				send_item(MODE_PAT, alphabet[$urandom_range(n_sym - 1)], 8'($urandom()));
				p_add--;
			end
		end
		repeat ($urandom_range(1, 5)) begin
			if ($urandom_range(4) == 0)
				pos = 8'($urandom());
			else
				pos = 8'($urandom_range(sb.text_len + 1));
			send_item(MODE_SEARCH, 8'($urandom()), pos);
		end
	endtask

	initial begin
		sb = new();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		run_full_stores();
		// phase 2 stands for receiver stalls; the receiver has no hold-off,
		// so it runs without gaps
		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = idle_by_phase[phase];
			for (int unsigned phase_end = sent_items + PHASE_ITEMS; sent_items < phase_end; )
				run_random_sequence();
		end

		// drop start and drain the outstanding results
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
